// ----- rtl/per_process_page_table_defines.svh -----
// Assertion macros shared by the page table RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef PER_PROCESS_PAGE_TABLE_DEFINES_SVH
`define PER_PROCESS_PAGE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define PPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds across reset.
`define PPT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPT_ASSERT(label, clk, rst_n, prop, msg)
`define PPT_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

// ----- rtl/ppt_pkg.sv -----
`default_nettype none

package ppt_pkg;

    // Default sizing of the block.
    localparam int PPT_SLOTS      = 4;
    localparam int PPT_PAGES      = 1024;
    localparam int PPT_PAGE_SHIFT = 12;

    // Fixed field widths of the beats.
    localparam int PPT_WORD_W = 32;
    localparam int PPT_SLOT_W = 2;
    localparam int PPT_VA_W   = 22;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_KILL   = 2'd1,
        CMD_ALLOC  = 2'd2,
        CMD_XLATE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SLOT  = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNMAPPED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // Request beat.
    typedef struct packed {
        t_cmd                  cmd;
        logic [PPT_WORD_W-1:0] proc_tag;
        logic [PPT_WORD_W-1:0] frame_in;
        logic [PPT_WORD_W-1:0] virt_addr;
    } t_req;

    // Response beat.
    typedef struct packed {
        t_status               status;
        logic [PPT_SLOT_W-1:0] slot;
        logic [PPT_VA_W-1:0]   virt_addr_out;
        logic [PPT_WORD_W-1:0] frame_out;
    } t_rsp;

    // Outcome of one command as decided by the slot controller.
    typedef struct packed {
        t_status               status;
        logic [PPT_SLOT_W-1:0] slot;
        logic [PPT_VA_W-1:0]   va_out;
        logic                  mem_we;
        logic                  mem_re;
    } t_slot_res;

endpackage

`default_nettype wire

// ----- rtl/per_process_page_table.sv -----
// A request beat is registered, executed in the execute state and loaded into the output
// register from the done state, which a stalled output holds; no request is taken during
// execution. The single port frame RAM is read in the execute state into a read register.
// Reset (synchronous, active low) frees all slots and zeroes every fill count; the frame
// RAM is not cleared and requests are taken right after reset.
`default_nettype none

`include "per_process_page_table_defines.svh"

module per_process_page_table
    import ppt_pkg::*;
#(
    parameter int SLOTS      = PPT_SLOTS,
    parameter int PAGES      = PPT_PAGES,
    parameter int PAGE_SHIFT = PPT_PAGE_SHIFT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = $clog2(PAGES);
    localparam int AW = SW + PW;

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    t_slot_res             r_res;
    logic                  r_out_valid;
    t_rsp                  r_out;

    t_slot_res             res;
    logic [AW-1:0]         mem_addr;
    logic [PPT_WORD_W-1:0] mem_rdata;
    logic                  in_beat;
    logic                  out_free;
    logic                  exec;

    // Slot table and command decision.
    ppt_slot_ctrl #(
        .SLOTS      (SLOTS),
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_slot_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_req   (r_req),
        .o_res   (res),
        .o_addr  (mem_addr)
    );

    // Frame store.
    ppt_frame_ram #(
        .AW (AW)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (exec && res.mem_we),
        .i_re    (exec && res.mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_req.frame_in),
        .o_rdata (mem_rdata)
    );

    // Sequencer: take a request, execute it, then present the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        o_in_ready = 1'b0;
        exec       = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                exec    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_in_ready = out_free;
                if (out_free) begin
                    n_state = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        in_beat = i_in_valid && o_in_ready;
    end

    // Request and decision registers.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req <= i_in;
        end
        if (exec) begin
            r_res <= res;
        end
    end

    // Output register; the frame comes from the RAM read data when the command read it, else zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.status        <= r_res.status;
            r_out.slot          <= r_res.slot;
            r_out.virt_addr_out <= r_res.va_out;
            r_out.frame_out     <= r_res.mem_re ? mem_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A taken request is always executed in the next cycle.
    `PPT_ASSERT(a_beat_exec, i_clk, i_rst_n, in_beat |=> (r_state == S_EXEC), "request beat not executed")
    // A new result only appears right after the result cycle.
    `PPT_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result without execution")
    // Reset leaves the block idle with no result pending.
    `PPT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "reset did not clear control state")

endmodule

`default_nettype wire

// ----- rtl/ppt_frame_ram.sv -----
`default_nettype none

module ppt_frame_ram
    import ppt_pkg::*;
#(
    parameter int AW = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [PPT_WORD_W-1:0] i_wdata,
    output logic      [PPT_WORD_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [PPT_WORD_W-1:0] r_mem [DEPTH];
    logic [PPT_WORD_W-1:0] r_rdata;

    // Single port frame store with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ppt_slot_ctrl.sv -----
`default_nettype none

`include "per_process_page_table_defines.svh"

module ppt_slot_ctrl
    import ppt_pkg::*;
#(
    parameter int SLOTS      = PPT_SLOTS,
    parameter int PAGES      = PPT_PAGES,
    parameter int PAGE_SHIFT = PPT_PAGE_SHIFT,
    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int PW        = $clog2(PAGES),
    localparam int AW        = SW + PW
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_exec,
    input  wire t_req    i_req,
    output t_slot_res    o_res,
    output logic [AW-1:0] o_addr
);

    localparam int CW = $clog2(PAGES + 1);

    // Slot table. Entries of a slot are always filled from page zero upward
    // and only emptied all at once, so a fill count stands in for valid bits.
    logic                  r_busy  [SLOTS];
    logic [PPT_WORD_W-1:0] r_owner [SLOTS];
    logic [CW-1:0]         r_fill  [SLOTS];

    logic                  match_hit;
    logic [SW-1:0]         match_sel;
    logic                  free_hit;
    logic [SW-1:0]         free_sel;
    logic [CW-1:0]         fill_sel;
    logic                  table_full;
    logic [PPT_WORD_W-1:0] page;
    logic                  page_mapped;
    logic [PPT_WORD_W-1:0] va_full;
    t_slot_res             res;

    // Lowest busy slot owned by the tag and lowest free slot.
    always_comb begin
        match_hit = 1'b0;
        match_sel = '0;
        free_hit  = 1'b0;
        free_sel  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_busy[s] && r_owner[s] == i_req.proc_tag) begin
                match_hit = 1'b1;
                match_sel = SW'(s);
            end
            if (!r_busy[s]) begin
                free_hit = 1'b1;
                free_sel = SW'(s);
            end
        end
        // The reserved tag never matches.
        if (i_req.proc_tag == '0) begin
            match_hit = 1'b0;
        end
    end

    // Page checks against the matched slot's fill count.
    always_comb begin
        fill_sel    = r_fill[match_sel];
        table_full  = (fill_sel == CW'(PAGES));
        page        = i_req.virt_addr >> PAGE_SHIFT;
        page_mapped = (page < PPT_WORD_W'(PAGES)) && (CW'(page[PW-1:0]) < fill_sel);
        va_full     = PPT_WORD_W'(fill_sel) << PAGE_SHIFT;
    end

    // Command decision.
    always_comb begin
        res.status = ST_OK;
        res.slot   = '0;
        res.va_out = '0;
        res.mem_we = 1'b0;
        res.mem_re = 1'b0;
        o_addr     = {match_sel, page[PW-1:0]};
        unique case (i_req.cmd)
            CMD_CREATE: begin
                if (i_req.proc_tag == '0) begin
                    res.status = ST_UNKNOWN;
                end else if (free_hit) begin
                    res.slot = PPT_SLOT_W'(free_sel);
                end else begin
                    res.status = ST_NO_SLOT;
                end
            end
            CMD_KILL, CMD_ALLOC, CMD_XLATE: begin
                if (!match_hit) begin
                    res.status = ST_UNKNOWN;
                end else begin
                    res.slot = PPT_SLOT_W'(match_sel);
                    if (i_req.cmd == CMD_ALLOC) begin
                        o_addr = {match_sel, fill_sel[PW-1:0]};
                        if (table_full) begin
                            res.status = ST_FULL;
                        end else begin
                            res.mem_we = 1'b1;
                            res.va_out = va_full[PPT_VA_W-1:0];
                        end
                    end else if (i_req.cmd == CMD_XLATE) begin
                        if (page_mapped) begin
                            res.mem_re = 1'b1;
                        end else begin
                            res.status = ST_UNMAPPED;
                        end
                    end
                end
            end
            default: begin
                res.status = ST_UNKNOWN;
            end
        endcase
    end

    assign o_res = res;

    // Slot table update, once per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_busy[s]  <= 1'b0;
                r_owner[s] <= '0;
                r_fill[s]  <= '0;
            end
        end else if (i_exec) begin
            if (i_req.cmd == CMD_CREATE && i_req.proc_tag != '0 && free_hit) begin
                r_busy[free_sel]  <= 1'b1;
                r_owner[free_sel] <= i_req.proc_tag;
            end
            if (i_req.cmd == CMD_KILL && match_hit) begin
                r_busy[match_sel]  <= 1'b0;
                r_owner[match_sel] <= '0;
                r_fill[match_sel]  <= '0;
            end
            if (res.mem_we) begin
                r_fill[match_sel] <= fill_sel + CW'(1);
            end
        end
    end

    // A mapped translate needs a table that holds at least one page.
    `PPT_ASSERT(a_read_nonempty, i_clk, i_rst_n, (i_exec && o_res.mem_re) |-> (fill_sel != '0), "translate read from an empty table")
    // A command never both stores and reads a frame.
    `PPT_ASSERT(a_we_re_excl, i_clk, i_rst_n, !(o_res.mem_we && o_res.mem_re), "frame store written and read by one command")

    // No fill count passes the table size.
    for (genvar g = 0; g < SLOTS; g++) begin : g_fill_chk
        `PPT_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill[g] <= CW'(PAGES), "fill count above table size")
    end

endmodule

`default_nettype wire
